// ===== src/fwrk_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fwrk_pkg - shared definitions for the keyed-removal FIFO
// Sizes, stream packing positions and request opcodes.
// -----------------------------------------------------------------------------
package fwrk_pkg;

   localparam int DEPTH      = 16;
   localparam int KEY_BITS   = 16;
   localparam int VALUE_BITS = 16;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS   = $clog2(DEPTH + 1);
   localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS;

   localparam int OP_BITS       = 2;
   localparam int REQ_DATA_BITS = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;

   // response tdata: key, value, count, empty flag from bit 0 up
   localparam int RSP_VALUE_LSB = KEY_BITS;
   localparam int RSP_CNT_LSB   = KEY_BITS + VALUE_BITS;
   localparam int RSP_EMPTY_BIT = RSP_CNT_LSB + CNT_BITS;
   localparam int RSP_USED_BITS = RSP_EMPTY_BIT + 1;
   localparam int RSP_DATA_BITS = ((RSP_USED_BITS + 7) / 8) * 8;

   typedef enum logic [OP_BITS-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_REMOVE  = 2'd2
   } opcode_type;

endpackage

// ===== src/fwrk_ram.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fwrk_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// -----------------------------------------------------------------------------
module fwrk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/fifo_with_remove_by_key.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fifo_with_remove_by_key - bounded FIFO of key/value pairs with keyed removal
// Enqueue at the tail, dequeue from the head, remove the first matching key.
// -----------------------------------------------------------------------------
// The queue is a compacting store in one RAM with the head at address 0, so
// one read port and one write port do all the work. An enqueue, and any
// request that fails at once (full, empty, unused opcode), is answered
// from the idle state. A dequeue or a remove first scans from the head, one
// entry per cycle through the registered read port, until the key matches
// (a dequeue matches the head), then moves every later entry down one
// place, again one per cycle. One request is in work at a time, and a new
// one is taken only after the previous item has left the response register.
// No clearing pass follows reset.
module fifo_with_remove_by_key (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // key_id, item_value
   input  logic [fwrk_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // opcode
   input  logic [fwrk_pkg::OP_BITS-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_key, out_value, entry_count, is_empty, zero pad
   output logic [fwrk_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // ok
   output logic                              rsp_tuser
);

   import fwrk_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [CNT_BITS-1:0]     rd_idx_ff, rd_idx_in;
   logic                    pend_ff, pend_in;
   logic [CNT_BITS-1:0]     pend_idx_ff, pend_idx_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic                    deq_ff, deq_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [KEY_BITS-1:0]     rsp_key_ff, rsp_key_in;
   logic [VALUE_BITS-1:0]   rsp_value_ff, rsp_value_in;
   logic [CNT_BITS-1:0]     rsp_count_ff, rsp_count_in;
   logic                    rsp_empty_ff, rsp_empty_in;

   logic                    ram_wr_en;
   logic [ADDR_BITS-1:0]    ram_wr_addr;
   logic [ENTRY_BITS-1:0]   ram_wr_data;
   logic [ADDR_BITS-1:0]    ram_rd_addr;
   logic [ENTRY_BITS-1:0]   ram_rd_data;

   logic                    req_accept;
   logic                    more_to_read;
   logic                    hit;
   logic [CNT_BITS-1:0]     shift_addr;
   logic [KEY_BITS-1:0]     req_key;
   logic [VALUE_BITS-1:0]   req_value;

   assign req_tready   = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_accept   = req_tvalid && req_tready;
   assign req_key      = req_tdata[KEY_BITS-1:0];
   assign req_value    = req_tdata[KEY_BITS +: VALUE_BITS];
   assign more_to_read = rd_idx_ff < count_ff;
   assign hit          = pend_ff && (deq_ff || (ram_rd_data[KEY_BITS-1:0] == key_ff));
   assign shift_addr   = pend_idx_ff - 1'b1;
   assign ram_rd_addr  = rd_idx_ff[ADDR_BITS-1:0];

   fwrk_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      key_in       = key_ff;
      deq_in       = deq_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      rsp_empty_in = rsp_empty_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               key_in       = req_key;
               deq_in       = 1'b0;
               rd_idx_in    = '0;
               pend_in      = 1'b0;
               // failure answer unless a branch below says otherwise
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_key_in   = '0;
               rsp_value_in = '0;
               rsp_count_in = count_ff;
               rsp_empty_in = (count_ff == '0);
               case (opcode_type'(req_tuser))
                  OP_ENQUEUE: begin
                     if (count_ff < CNT_BITS'(DEPTH)) begin
                        ram_wr_en    = 1'b1;
                        ram_wr_addr  = count_ff[ADDR_BITS-1:0];
                        ram_wr_data  = {req_value, req_key};
                        count_in     = count_ff + 1'b1;
                        rsp_ok_in    = 1'b1;
                        rsp_key_in   = req_key;
                        rsp_value_in = req_value;
                        rsp_count_in = count_ff + 1'b1;
                        rsp_empty_in = 1'b0;
                     end
                  end
                  OP_DEQUEUE, OP_REMOVE: begin
                     if (count_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        deq_in       = (opcode_type'(req_tuser) == OP_DEQUEUE);
                        state_in     = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (more_to_read) begin
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff;
               rd_idx_in   = rd_idx_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (hit) begin
               // hold the hit in the response register, restart reads after it
               rsp_key_in   = ram_rd_data[KEY_BITS-1:0];
               rsp_value_in = ram_rd_data[KEY_BITS +: VALUE_BITS];
               rd_idx_in    = pend_idx_ff + 1'b1;
               pend_in      = 1'b0;
               state_in     = ST_SHIFT;
            end else if (!pend_ff && !more_to_read) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_key_in   = '0;
               rsp_value_in = '0;
               rsp_count_in = count_ff;
               rsp_empty_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         ST_SHIFT: begin
            if (more_to_read) begin
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff;
               rd_idx_in   = rd_idx_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               // move the entry just read down one place
               ram_wr_en   = 1'b1;
               ram_wr_addr = shift_addr[ADDR_BITS-1:0];
               ram_wr_data = ram_rd_data;
            end
            if (!pend_ff && !more_to_read) begin
               count_in     = count_ff - 1'b1;
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_count_in = count_ff - 1'b1;
               rsp_empty_in = (count_ff == CNT_BITS'(1));
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_idx_ff  <= pend_idx_in;
      key_ff       <= key_in;
      deq_ff       <= deq_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_empty_ff, rsp_count_ff, rsp_value_ff, rsp_key_ff});

endmodule

// ===== src/fwrk_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fwrk_assertions - port-level checks for the keyed-removal FIFO
// Watches the request and response streams of the top level.
// -----------------------------------------------------------------------------
module fwrk_assertions (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [fwrk_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input logic [fwrk_pkg::OP_BITS-1:0]       req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [fwrk_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                              rsp_tuser
);

   import fwrk_pkg::*;

   logic [CNT_BITS-1:0] rsp_count;

   assign rsp_count = rsp_tdata[RSP_CNT_LSB +: CNT_BITS];

   // a stalled response item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response item changed while stalled");

   // only one item in work: no new request while a response waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while a response is pending");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_EMPTY_BIT] == (rsp_count == '0)))
      else $error("empty flag disagrees with entry count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_count <= CNT_BITS'(DEPTH)))
      else $error("entry count above depth");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata[RSP_CNT_LSB-1:0] == '0))
      else $error("failed response carries nonzero key or value");

endmodule

bind fifo_with_remove_by_key fwrk_assertions u_fwrk_assertions (.*);

// ===== verif/fwrk_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fwrk_checker - scoreboard for the keyed-removal FIFO
// Watches both stream channels, keeps its own copy of the queue contents,
// predicts one reply per accepted request and compares replies in order.
// -----------------------------------------------------------------------------
module fwrk_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   // key_id, item_value
   input  logic [fwrk_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // opcode
   input  logic [fwrk_pkg::OP_BITS-1:0]       req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_key, out_value, entry_count, is_empty, zero pad
   input  logic [fwrk_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // ok
   input  logic                               rsp_tuser,
   output int unsigned                        error_count,
   output int unsigned                        pending
);

   import fwrk_pkg::*;

   typedef struct packed {
      logic                  ok;
      logic [KEY_BITS-1:0]   out_key;
      logic [VALUE_BITS-1:0] out_value;
      logic [CNT_BITS-1:0]   entry_count;
      logic                  is_empty;
   } queue_reply_type;

   queue_reply_type       expected_replies[$];
   logic [KEY_BITS-1:0]   pair_keys[DEPTH];
   logic [VALUE_BITS-1:0] pair_values[DEPTH];
   logic [CNT_BITS-1:0]   pair_count;

   // Apply one request to the shadow queue and return the reply it earns.
   task automatic apply_request(input logic [OP_BITS-1:0] op,
                                input logic [KEY_BITS-1:0] key,
                                input logic [VALUE_BITS-1:0] val,
                                output queue_reply_type reply);
      int hit;
      int i;
      reply = '0;
      hit   = -1;
      case (op)
         OP_ENQUEUE: begin
            if (pair_count < DEPTH) begin
               pair_keys[pair_count[ADDR_BITS-1:0]]   = key;
               pair_values[pair_count[ADDR_BITS-1:0]] = val;
               pair_count              = pair_count + 1'b1;
               reply.ok                = 1'b1;
               reply.out_key           = key;
               reply.out_value         = val;
            end
         end
         OP_DEQUEUE: begin
            if (pair_count > 0) hit = 0;
         end
         OP_REMOVE: begin
            for (i = 0; i < pair_count; i++) begin
               if (hit < 0 && pair_keys[i] == key) hit = i;
            end
         end
         default: ;
      endcase
      if (hit >= 0) begin
         reply.ok        = 1'b1;
         reply.out_key   = pair_keys[hit];
         reply.out_value = pair_values[hit];
         // close the gap, keeping the order of later entries
         for (i = hit; i + 1 < pair_count; i++) begin
            pair_keys[i]   = pair_keys[i + 1];
            pair_values[i] = pair_values[i + 1];
         end
         pair_count = pair_count - 1'b1;
      end
      reply.entry_count = pair_count;
      reply.is_empty    = (pair_count == 0);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      queue_reply_type predicted;
      queue_reply_type seen;
      queue_reply_type want;
      if (reset) begin
         expected_replies.delete();
         pair_count = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_request(req_tuser, req_tdata[KEY_BITS-1:0],
                          req_tdata[KEY_BITS +: VALUE_BITS], predicted);
            expected_replies.push_back(predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.ok          = rsp_tuser;
            seen.out_key     = rsp_tdata[KEY_BITS-1:0];
            seen.out_value   = rsp_tdata[RSP_VALUE_LSB +: VALUE_BITS];
            seen.entry_count = rsp_tdata[RSP_CNT_LSB +: CNT_BITS];
            seen.is_empty    = rsp_tdata[RSP_EMPTY_BIT];
            if (expected_replies.size() == 0) begin
               $error("reply item with no request waiting: ok=%0b key=0x%0h value=0x%0h",
                      seen.ok, seen.out_key, seen.out_value);
               error_count++;
            end else begin
               want = expected_replies.pop_front();
               compare_field("ok", 32'(want.ok), 32'(seen.ok));
               compare_field("out_key", 32'(want.out_key), 32'(seen.out_key));
               compare_field("out_value", 32'(want.out_value), 32'(seen.out_value));
               compare_field("entry_count", 32'(want.entry_count),
                             32'(seen.entry_count));
               compare_field("is_empty", 32'(want.is_empty), 32'(seen.is_empty));
            end
         end
      end
      pending = expected_replies.size();
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb - testbench top for the keyed-removal FIFO
// Drives directed and random enqueue, dequeue and remove requests in bursts,
// stalls the reply side on its own pattern, and reports the scoreboard verdict.
// -----------------------------------------------------------------------------
module tb;
   import fwrk_pkg::*;

   localparam int          CLOCK_PERIOD = 12;
   localparam int          RESET_CYCLES = 11;
   localparam int          RANDOM_ITEMS = 1150;
   localparam int          DRAIN_CYCLES = 60;
   localparam int          HOLD_CYCLES  = 500;
   localparam int unsigned LIMIT_CYCLES = 400000;
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [OP_BITS-1:0]       req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;
   int unsigned              error_count;
   int unsigned              pending;

   logic [KEY_BITS-1:0]      key_pool[8];

   fifo_with_remove_by_key dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   fwrk_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .error_count (error_count),
      .pending     (pending)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2.0) clock = ~clock;
   end

   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("DONE: errors detected");
      $finish;
   end

   // Offer one request item and hold it until the block takes it.
   task automatic send_item(input logic [OP_BITS-1:0] op, input logic [KEY_BITS-1:0] key,
                            input logic [VALUE_BITS-1:0] val);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {val, key};
      do @(posedge clock); while (!req_tready);
   endtask

   // Reply side: stretches of different stall patterns, one long hold-off.
   initial begin : reply_side
      int mode;
      int len;
      int i;
      int stretch;
      wait (reset == 1'b0);
      stretch = 0;
      forever begin
         mode = $urandom_range(0, 3);
         len  = $urandom_range(8, 80);
         for (i = 0; i < len; i++) begin
            @(posedge clock);
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (i % 5 != 4);
            endcase
         end
         stretch++;
         if (stretch == 6) begin
            // hold off long enough that the block backs up into its input
            @(posedge clock);
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
      end
   end

   initial begin : request_side
      int i;
      int sent;
      int burst;
      int gap;
      int enq_pct;
      logic [OP_BITS-1:0]    op;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] val;

      key_pool[0] = '0;
      key_pool[1] = '1;
      for (i = 2; i < 8; i++) key_pool[i] = KEY_BITS'($urandom);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // empty queue: every request fails
      send_item(OP_DEQUEUE, 16'h0000, 16'h0000);
      send_item(OP_REMOVE, 16'h0000, 16'h0000);
      send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF);
      // extreme pairs, then fill to the top with repeated keys
      send_item(OP_ENQUEUE, 16'h0000, 16'h0000);
      send_item(OP_ENQUEUE, 16'hFFFF, 16'hFFFF);
      for (i = 0; i < DEPTH - 2; i++) begin
         send_item(OP_ENQUEUE, KEY_BITS'(16'h00A0 + (i % 4)), VALUE_BITS'(16'h0100 + i));
      end
      // full queue: enqueue and unused opcode fail
      send_item(OP_ENQUEUE, 16'h5A5A, 16'hA5A5);
      send_item(OP_UNUSED, 16'h00A0, 16'h1111);
      // remove from the middle, a missing key, the first of duplicates
      send_item(OP_REMOVE, 16'hFFFF, 16'h0000);
      send_item(OP_REMOVE, 16'h1234, 16'h0000);
      send_item(OP_REMOVE, 16'h00A1, 16'h0000);
      send_item(OP_DEQUEUE, 16'h0000, 16'h0000);

      sent    = 0;
      enq_pct = 50;
      gap     = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 16);
         for (i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
            // swing between filling and draining so both ends get exercised
            if (sent % 64 == 0) enq_pct = $urandom_range(15, 85);
            if ($urandom_range(0, 99) < 3) op = OP_UNUSED;
            else if ($urandom_range(0, 99) < enq_pct) op = OP_ENQUEUE;
            else if ($urandom_range(0, 1) == 0) op = OP_DEQUEUE;
            else op = OP_REMOVE;
            if ($urandom_range(0, 4) != 0) key = key_pool[$urandom_range(0, 7)];
            else key = KEY_BITS'($urandom);
            val = VALUE_BITS'($urandom);
            send_item(op, key, val);
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (gap == 0) req_tvalid <= 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      if (error_count == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
